FILE: rtl/core/imma_pkg.sv
`default_nettype none

package imma_pkg;

   localparam int WORD_W = 32;
   localparam int DIM_W  = 4;
   localparam int CNT_W  = 2 * DIM_W;
   localparam int REQ_W  = 3 * WORD_W;

   localparam logic [DIM_W-1:0] SIZE_RESET = 4'd8;

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_WAIT  = 3'b010,
      ST_ISSUE = 3'b100
   } state_type;

   // flags that travel with each multiply term
   typedef struct packed {
      logic vld;
      logic first;
      logic fin;
      logic tlast;
   } term_type;

endpackage

`default_nettype wire

FILE: rtl/core/int_matrix_multiply_accumulate.sv
`default_nettype none
// Loading: one word per cycle; the word that completes N*N elements starts the compute pass.
// Each result entry takes N reads of the A and B memories through one
// 32x32 multiplier, two pipeline stages and a handoff of the output register.
// The first result follows the last accepted word through ST_WAIT and ST_ISSUE; no word is taken
// while results other than the final one are pending.
// Synchronous active-high reset resets control state; memory contents stay undefined.
module int_matrix_multiply_accumulate
   import imma_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [DIM_W-1:0] csr_data,   // matrix_size
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // a_elem, b_elem, c_elem
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [WORD_W-1:0]     rsp_tdata,  // result_elem
   output logic                  rsp_tlast
);

   localparam int DIM_CAP = (1 << DIM_W) - 1;
   localparam int EFF_DIM = (MAX_DIM < DIM_CAP) ? MAX_DIM : DIM_CAP;
   localparam int CELLS   = EFF_DIM * EFF_DIM;
   localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1;

   logic [WORD_W-1:0] mem_a   [CELLS];
   logic [WORD_W-1:0] mem_b   [CELLS];
   logic [WORD_W-1:0] mem_acc [CELLS];

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  size_ff, size_in;
   logic [AW-1:0]     fill_ff, fill_in;
   logic [AW-1:0]     cell_ff, cell_in;
   logic [AW-1:0]     row_ff, row_in;
   logic [AW-1:0]     aad_ff, aad_in;
   logic [AW-1:0]     bad_ff, bad_in;
   logic [DIM_W-1:0]  j_ff, j_in;
   logic [DIM_W-1:0]  k_ff, k_in;

   term_type          t1_ff, t1_in;
   term_type          t2_ff;
   logic [WORD_W-1:0] a_q_ff, b_q_ff, acc_q_ff;
   logic [WORD_W-1:0] prod_ff, acc2_ff;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic              rsp_vld_ff;
   logic [WORD_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;

   logic [DIM_W-1:0]  n_use;
   logic [CNT_W-1:0]  total_m1;
   logic              wr_en;
   logic              rd_en;
   logic              cfg_wr;
   logic              pipe_idle;

   always_comb begin
      n_use = size_ff;
      if (size_ff == '0) begin
         n_use = DIM_W'(1);
      end else if (int'(size_ff) > MAX_DIM) begin
         n_use = DIM_W'(MAX_DIM);
      end
      total_m1 = CNT_W'(n_use) * CNT_W'(n_use) - CNT_W'(1);
   end

   assign csr_ready  = (state_ff == ST_LOAD);
   assign cfg_wr     = csr_valid & csr_ready;
   assign req_tready = (state_ff == ST_LOAD);
   assign wr_en      = req_tvalid & req_tready;
   assign rd_en      = (state_ff == ST_ISSUE);
   assign pipe_idle  = !t1_ff.vld && !t2_ff.vld && !rsp_vld_ff;

   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      fill_in  = fill_ff;
      cell_in  = cell_ff;
      row_in   = row_ff;
      aad_in   = aad_ff;
      bad_in   = bad_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      t1_in    = '0;

      case (state_ff)
         ST_LOAD: begin
            if (cfg_wr) begin
               size_in = csr_data;
               fill_in = '0;
            end else if (wr_en) begin
               if (CNT_W'(fill_ff) == total_m1) begin
                  fill_in  = '0;
                  cell_in  = '0;
                  row_in   = '0;
                  aad_in   = '0;
                  bad_in   = '0;
                  j_in     = '0;
                  k_in     = '0;
                  state_in = ST_WAIT;
               end else begin
                  fill_in = fill_ff + AW'(1);
               end
            end
         end
         ST_WAIT: begin
            // hold until the previous entry has left the output register
            if (pipe_idle) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            t1_in.vld   = 1'b1;
            t1_in.first = (k_ff == '0);
            t1_in.fin   = (k_ff == n_use - DIM_W'(1));
            t1_in.tlast = (CNT_W'(cell_ff) == total_m1);
            if (t1_in.fin) begin
               k_in    = '0;
               cell_in = cell_ff + AW'(1);
               if (j_ff == n_use - DIM_W'(1)) begin
                  j_in   = '0;
                  row_in = row_ff + AW'(n_use);
                  aad_in = row_ff + AW'(n_use);
                  bad_in = '0;
               end else begin
                  j_in   = j_ff + DIM_W'(1);
                  aad_in = row_ff;
                  bad_in = AW'(j_ff + DIM_W'(1));
               end
               state_in = t1_in.tlast ? ST_LOAD : ST_WAIT;
            end else begin
               k_in   = k_ff + DIM_W'(1);
               aad_in = aad_ff + AW'(1);
               bad_in = bad_ff + AW'(n_use);
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         size_ff  <= SIZE_RESET;
         fill_ff  <= '0;
         t1_ff    <= '0;
         t2_ff    <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         fill_ff  <= fill_in;
         t1_ff    <= t1_in;
         t2_ff    <= t1_ff;
      end
      cell_ff <= cell_in;
      row_ff  <= row_in;
      aad_ff  <= aad_in;
      bad_ff  <= bad_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
   end

   // memories: one write port for loading, one registered read port for compute
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[fill_ff]   <= req_tdata[WORD_W-1:0];
         mem_b[fill_ff]   <= req_tdata[2*WORD_W-1:WORD_W];
         mem_acc[fill_ff] <= req_tdata[3*WORD_W-1:2*WORD_W];
      end
      if (rd_en) begin
         a_q_ff   <= mem_a[aad_ff];
         b_q_ff   <= mem_b[bad_ff];
         acc_q_ff <= mem_acc[cell_ff];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_q_ff * b_q_ff;
      acc2_ff <= acc_q_ff;
      if (t2_ff.vld) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_in = (t2_ff.first ? acc2_ff : sum_ff) + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (t2_ff.vld && t2_ff.fin) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (t2_ff.vld && t2_ff.fin) begin
         rsp_data_ff <= sum_in;
         rsp_last_ff <= t2_ff.tlast;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/imma_checker.sv
`default_nettype none

module imma_checker
   import imma_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [WORD_W-1:0] rsp_tdata,
   input wire logic              rsp_tlast
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // no new result can be valid in the cycle right after a handoff
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("result register refilled too early");

   // loading only resumes once the matrix is down to its final entry
   a_no_load_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken while results still pending");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind int_matrix_multiply_accumulate imma_checker u_imma_checker (.*);

`default_nettype wire
